>>> hw/rtl/rag_pkg.sv
// ----------------------------------------------------------------------------
// Reorg address generator package
// Shared constants, register indices and sequencer types for the
// space-to-depth address generator.
// ----------------------------------------------------------------------------
package rag_pkg;

  // Default sizing of the generator.
  localparam int unsigned DefMaxWidth    = 1024;
  localparam int unsigned DefMaxHeight   = 1024;
  localparam int unsigned DefMaxChannels = 4096;
  localparam int unsigned DefMaxBatch    = 64;
  localparam int unsigned DefAddrBits    = 40;

  // Field widths of the configuration registers.
  localparam int unsigned WidthFieldW    = 11;
  localparam int unsigned HeightFieldW   = 11;
  localparam int unsigned ChannelsFieldW = 13;
  localparam int unsigned BatchFieldW    = 7;
  localparam int unsigned StrideFieldW   = 4;

  // Configuration port shape.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  // Stride limits: the stride saturates at eight, so the offset inside a
  // block row needs three bits and a stride value four.
  localparam int unsigned StrideMax = 8;
  localparam int unsigned StrideW   = 4;
  localparam int unsigned BoModW    = 3;

  // Register indices.
  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_CHANNELS = 3'd2,
    REG_BATCH    = 3'd3,
    REG_STRIDE   = 3'd4,
    REG_FORWARD  = 3'd5
  } cfg_reg_e;

  // States of the sequencer that derives the per-shape constants.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_PREP,
    SEQ_DIV,
    SEQ_MUL,
    SEQ_FULL
  } seq_state_e;

  // Control strobes of the sequencer.
  typedef struct packed {
    logic busy;
    logic prep;
    logic div_step;
    logic mul;
    logic full;
  } seq_ctrl_t;

endpackage

>>> hw/rtl/rag_if.sv
// ----------------------------------------------------------------------------
// Reorg address generator channels
// Valid/ready interfaces for the step requests, the address pairs and the
// configuration writes.
// ----------------------------------------------------------------------------

// Step request channel.
interface rag_step_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// Address pair channel.
interface rag_addr_if #(
  parameter int unsigned ADDR_BITS = rag_pkg::DefAddrBits
);
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] source_address;
  logic [ADDR_BITS-1:0] dest_address;
  logic                 last;

  modport source (output valid, output source_address, output dest_address, output last,
                  input ready);
  modport sink (input valid, input source_address, input dest_address, input last,
                output ready);
endinterface

// Configuration write channel.
interface rag_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rag_pkg::CfgIdxW-1:0]  index;
  logic [rag_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/reorg_address_generator_core.sv
// ----------------------------------------------------------------------------
// Reorg address generator core
// Emits one source/destination address pair per step request, walking a
// tensor in linear input order and mapping it through space-to-depth.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on step_i asks for one address pair; restart high begins again at
// the first element, otherwise the walk advances and wraps after the element
// flagged last. Pairs leave on addr_o through an output register, in the cycle
// after the step beat is taken. Throughput is one pair per cycle while step_i
// is ready: the permuted address is kept as running sums, so each step costs
// one adder and a few compares. A stalled receiver holds the pair in the
// output register; a new step is taken in the cycle that the waiting pair
// leaves. Configuration beats on cfg_i are always taken. Each valid write to
// a decoded index returns the walk to the first element and starts a sequencer
// that derives the shape constants: a restoring divide for the output channel
// count, one quotient bit per cycle, and three multiply steps, so step_i
// stays low until the sequencer is back in idle.
// Reset loads every dimension with one and forward mode, clears the walk and
// leaves the output empty.
// ----------------------------------------------------------------------------
module reorg_address_generator_core #(
  parameter int unsigned MAX_WIDTH    = rag_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT   = rag_pkg::DefMaxHeight,
  parameter int unsigned MAX_CHANNELS = rag_pkg::DefMaxChannels,
  parameter int unsigned MAX_BATCH    = rag_pkg::DefMaxBatch,
  parameter int unsigned ADDR_BITS    = rag_pkg::DefAddrBits
) (
  input logic     clk_i,
  input logic     rst_ni,
  rag_cfg_if.sink cfg_i,
  rag_step_if.sink step_i,
  rag_addr_if.source addr_o
);

  // Widths of the stored dimensions and of the walk counters.
  localparam int unsigned WDimW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HDimW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CDimW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned BDimW = $clog2(MAX_BATCH + 1);
  localparam int unsigned ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned ChW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned ImgW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int unsigned SW    = rag_pkg::StrideW;
  localparam int unsigned SsW   = 2 * SW;
  localparam int unsigned WsW   = WDimW + SW;
  localparam int unsigned HsW   = HDimW + SW;
  localparam int unsigned WssW  = WsW + SW;
  localparam int unsigned WshsW = WsW + HsW;
  localparam int unsigned FullW = WshsW + CDimW;
  localparam int unsigned DCntW = (CDimW > 1) ? $clog2(CDimW) : 1;

  // Configuration registers, saturated on write.
  logic [WDimW-1:0] w_q;
  logic [HDimW-1:0] h_q;
  logic [CDimW-1:0] c_q;
  logic [BDimW-1:0] b_q;
  logic [SW-1:0]    s_q;
  logic             fwd_q;

  // Derived shape constants.
  logic [SsW-1:0]       ss_q;
  logic [WsW-1:0]       ws_q;
  logic [HsW-1:0]       hs_q;
  logic [WssW-1:0]      wss_q;
  logic [WshsW-1:0]     wshs_q;
  logic [CDimW-1:0]     oc_q;
  logic [ADDR_BITS-1:0] full_q;
  logic [ADDR_BITS-1:0] ws_adj_q;

  // Divider state.
  logic [CDimW-1:0] div_q;
  logic [SsW-1:0]   rem_q;
  logic [DCntW-1:0] dcnt_q;
  logic [SsW-1:0]   trial;
  logic             trial_ge;

  // Sequencer.
  rag_pkg::seq_state_e state_q, state_d;
  rag_pkg::seq_ctrl_t  ctrl;

  // Walk position and running addresses.
  logic [ColW-1:0]            col_q, col_d, cur_col;
  logic [RowW-1:0]            row_q, row_d, cur_row;
  logic [ChW-1:0]             ch_q, ch_d, cur_ch;
  logic [ImgW-1:0]            img_q, img_d, cur_img;
  logic [ChW-1:0]             ocr_q, ocr_d, cur_ocr;
  logic [rag_pkg::BoModW-1:0] bom_q, bom_d, cur_bom;
  logic [ADDR_BITS-1:0]       lin_q, lin_d, cur_lin;
  logic [ADDR_BITS-1:0]       perm_q, perm_d, cur_perm;
  logic [ADDR_BITS-1:0]       rs_q, rs_d, cur_rs;
  logic [ADDR_BITS-1:0]       cs_q, cs_d, cur_cs;
  logic [ADDR_BITS-1:0]       grp_q, grp_d, cur_grp;
  logic [ADDR_BITS-1:0]       ib_q, ib_d, cur_ib;

  // End-of-dimension flags of the current element.
  logic col_end, row_end, ch_end, img_end, ocr_end, bo_end, is_last;

  // Output register.
  logic                 out_valid_q;
  logic [ADDR_BITS-1:0] out_src_q;
  logic [ADDR_BITS-1:0] out_dst_q;
  logic                 out_last_q;

  // Handshakes.
  logic cfg_we;
  logic cfg_hit;
  logic step_acc;

  // Saturated configuration values.
  logic [rag_pkg::WidthFieldW-1:0]    wv;
  logic [rag_pkg::HeightFieldW-1:0]   hv;
  logic [rag_pkg::ChannelsFieldW-1:0] cv;
  logic [rag_pkg::BatchFieldW-1:0]    bv;
  logic [rag_pkg::StrideFieldW-1:0]   sv;
  logic [WDimW-1:0] w_sat;
  logic [HDimW-1:0] h_sat;
  logic [CDimW-1:0] c_sat;
  logic [BDimW-1:0] b_sat;
  logic [SW-1:0]    s_sat;

  // Handshake decode.
  assign cfg_i.ready  = 1'b1;
  assign cfg_we       = cfg_i.valid;
  assign step_i.ready = !ctrl.busy && !cfg_i.valid && (!out_valid_q || addr_o.ready);
  assign step_acc     = step_i.valid && step_i.ready;

  // Field extraction and saturation of a configuration write.
  always_comb begin
    wv = cfg_i.data[rag_pkg::WidthFieldW-1:0];
    hv = cfg_i.data[rag_pkg::HeightFieldW-1:0];
    cv = cfg_i.data[rag_pkg::ChannelsFieldW-1:0];
    bv = cfg_i.data[rag_pkg::BatchFieldW-1:0];
    sv = cfg_i.data[rag_pkg::StrideFieldW-1:0];
    w_sat = (wv == '0) ? WDimW'(1) :
            (32'(wv) > 32'(MAX_WIDTH)) ? WDimW'(MAX_WIDTH) : WDimW'(wv);
    h_sat = (hv == '0) ? HDimW'(1) :
            (32'(hv) > 32'(MAX_HEIGHT)) ? HDimW'(MAX_HEIGHT) : HDimW'(hv);
    c_sat = (cv == '0) ? CDimW'(1) :
            (32'(cv) > 32'(MAX_CHANNELS)) ? CDimW'(MAX_CHANNELS) : CDimW'(cv);
    b_sat = (bv == '0) ? BDimW'(1) :
            (32'(bv) > 32'(MAX_BATCH)) ? BDimW'(MAX_BATCH) : BDimW'(bv);
    s_sat = (sv == '0) ? SW'(1) :
            (32'(sv) > 32'(rag_pkg::StrideMax)) ? SW'(rag_pkg::StrideMax) : SW'(sv);
  end

  // Index decode: unknown indices are ignored altogether.
  always_comb begin
    unique case (cfg_i.index)
      rag_pkg::REG_WIDTH,
      rag_pkg::REG_HEIGHT,
      rag_pkg::REG_CHANNELS,
      rag_pkg::REG_BATCH,
      rag_pkg::REG_STRIDE,
      rag_pkg::REG_FORWARD: cfg_hit = cfg_we;
      default:              cfg_hit = 1'b0;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= WDimW'(1);
      h_q   <= HDimW'(1);
      c_q   <= CDimW'(1);
      b_q   <= BDimW'(1);
      s_q   <= SW'(1);
      fwd_q <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        rag_pkg::REG_WIDTH:    w_q   <= w_sat;
        rag_pkg::REG_HEIGHT:   h_q   <= h_sat;
        rag_pkg::REG_CHANNELS: c_q   <= c_sat;
        rag_pkg::REG_BATCH:    b_q   <= b_sat;
        rag_pkg::REG_STRIDE:   s_q   <= s_sat;
        rag_pkg::REG_FORWARD:  fwd_q <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer next state; a new write to a decoded index always starts it over.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rag_pkg::SEQ_IDLE: state_d = rag_pkg::SEQ_IDLE;
      rag_pkg::SEQ_PREP: state_d = rag_pkg::SEQ_DIV;
      rag_pkg::SEQ_DIV:  state_d = (dcnt_q == '0) ? rag_pkg::SEQ_MUL : rag_pkg::SEQ_DIV;
      rag_pkg::SEQ_MUL:  state_d = rag_pkg::SEQ_FULL;
      rag_pkg::SEQ_FULL: state_d = rag_pkg::SEQ_IDLE;
      default:           state_d = rag_pkg::SEQ_IDLE;
    endcase
    if (cfg_hit) begin
      state_d = rag_pkg::SEQ_PREP;
    end
  end

  // Sequencer strobes.
  always_comb begin
    ctrl          = '0;
    ctrl.busy     = (state_q != rag_pkg::SEQ_IDLE);
    ctrl.prep     = (state_q == rag_pkg::SEQ_PREP);
    ctrl.div_step = (state_q == rag_pkg::SEQ_DIV);
    ctrl.mul      = (state_q == rag_pkg::SEQ_MUL);
    ctrl.full     = (state_q == rag_pkg::SEQ_FULL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rag_pkg::SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // One restoring divide step: bring down the next dividend bit.
  assign trial    = {rem_q[SsW-2:0], div_q[CDimW-1]};
  assign trial_ge = (trial >= ss_q);

  // Shape constants: stride products, output channel count and plane sizes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_q     <= SsW'(1);
      ws_q     <= WsW'(1);
      hs_q     <= HsW'(1);
      wss_q    <= WssW'(1);
      wshs_q   <= WshsW'(1);
      oc_q     <= CDimW'(1);
      full_q   <= ADDR_BITS'(1);
      ws_adj_q <= ADDR_BITS'(1);
      div_q    <= '0;
      rem_q    <= '0;
      dcnt_q   <= '0;
    end else begin
      if (ctrl.prep) begin
        ss_q   <= SsW'(s_q) * SsW'(s_q);
        ws_q   <= WsW'(w_q) * WsW'(s_q);
        hs_q   <= HsW'(h_q) * HsW'(s_q);
        div_q  <= c_q;
        rem_q  <= '0;
        dcnt_q <= DCntW'(CDimW - 1);
      end
      if (ctrl.div_step) begin
        rem_q  <= trial_ge ? (trial - ss_q) : trial;
        div_q  <= (div_q << 1) | CDimW'(trial_ge);
        dcnt_q <= dcnt_q - DCntW'(1);
      end
      if (ctrl.mul) begin
        oc_q     <= (div_q == '0) ? CDimW'(1) : div_q;
        wss_q    <= WssW'(ws_q) * WssW'(s_q);
        wshs_q   <= WshsW'(ws_q) * WshsW'(hs_q);
        ws_adj_q <= ADDR_BITS'(ws_q) - ADDR_BITS'(s_q) + ADDR_BITS'(1);
      end
      if (ctrl.full) begin
        full_q <= ADDR_BITS'(FullW'(wshs_q) * FullW'(oc_q));
      end
    end
  end

  // Current element: the stored position, or the first element on restart.
  always_comb begin
    if (step_i.restart) begin
      cur_col  = '0;
      cur_row  = '0;
      cur_ch   = '0;
      cur_img  = '0;
      cur_ocr  = '0;
      cur_bom  = '0;
      cur_lin  = '0;
      cur_perm = '0;
      cur_rs   = '0;
      cur_cs   = '0;
      cur_grp  = '0;
      cur_ib   = '0;
    end else begin
      cur_col  = col_q;
      cur_row  = row_q;
      cur_ch   = ch_q;
      cur_img  = img_q;
      cur_ocr  = ocr_q;
      cur_bom  = bom_q;
      cur_lin  = lin_q;
      cur_perm = perm_q;
      cur_rs   = rs_q;
      cur_cs   = cs_q;
      cur_grp  = grp_q;
      cur_ib   = ib_q;
    end
  end

  // End flags of the current element.
  assign col_end = (WDimW'(cur_col) + WDimW'(1) == w_q);
  assign row_end = (HDimW'(cur_row) + HDimW'(1) == h_q);
  assign ch_end  = (CDimW'(cur_ch) + CDimW'(1) == c_q);
  assign img_end = (BDimW'(cur_img) + BDimW'(1) == b_q);
  assign ocr_end = (CDimW'(cur_ocr) + CDimW'(1) == oc_q);
  assign bo_end  = (SW'(cur_bom) + SW'(1) == s_q);
  assign is_last = col_end && row_end && ch_end && img_end;

  // Advance to the next element. The permuted address is tracked through the
  // starts of the current row, channel, channel group and image, so each
  // case needs only one addition.
  always_comb begin
    col_d  = cur_col;
    row_d  = cur_row;
    ch_d   = cur_ch;
    img_d  = cur_img;
    ocr_d  = cur_ocr;
    bom_d  = cur_bom;
    perm_d = cur_perm;
    rs_d   = cur_rs;
    cs_d   = cur_cs;
    grp_d  = cur_grp;
    ib_d   = cur_ib;
    lin_d  = is_last ? '0 : (cur_lin + ADDR_BITS'(1));
    priority if (!col_end) begin
      col_d  = cur_col + ColW'(1);
      perm_d = cur_perm + ADDR_BITS'(s_q);
    end else if (!row_end) begin
      col_d  = '0;
      row_d  = cur_row + RowW'(1);
      rs_d   = cur_rs + ADDR_BITS'(wss_q);
      perm_d = rs_d;
    end else if (!ch_end) begin
      col_d = '0;
      row_d = '0;
      ch_d  = cur_ch + ChW'(1);
      if (!ocr_end) begin
        ocr_d = cur_ocr + ChW'(1);
        cs_d  = cur_cs + ADDR_BITS'(wshs_q);
      end else begin
        // Channel group wraps: step the block offset, carrying into the
        // row part of the offset when the column part wraps.
        ocr_d = '0;
        bom_d = bo_end ? '0 : (cur_bom + rag_pkg::BoModW'(1));
        grp_d = cur_grp + (bo_end ? ws_adj_q : ADDR_BITS'(1));
        cs_d  = grp_d;
      end
      rs_d   = cs_d;
      perm_d = cs_d;
    end else begin
      col_d  = '0;
      row_d  = '0;
      ch_d   = '0;
      ocr_d  = '0;
      bom_d  = '0;
      img_d  = img_end ? '0 : (cur_img + ImgW'(1));
      ib_d   = img_end ? '0 : (cur_ib + full_q);
      grp_d  = ib_d;
      cs_d   = ib_d;
      rs_d   = ib_d;
      perm_d = ib_d;
    end
  end

  // Walk position; a valid write to a decoded index returns it to the start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ch_q   <= '0;
      img_q  <= '0;
      ocr_q  <= '0;
      bom_q  <= '0;
      lin_q  <= '0;
      perm_q <= '0;
      rs_q   <= '0;
      cs_q   <= '0;
      grp_q  <= '0;
      ib_q   <= '0;
    end else if (cfg_hit) begin
      col_q  <= '0;
      row_q  <= '0;
      ch_q   <= '0;
      img_q  <= '0;
      ocr_q  <= '0;
      bom_q  <= '0;
      lin_q  <= '0;
      perm_q <= '0;
      rs_q   <= '0;
      cs_q   <= '0;
      grp_q  <= '0;
      ib_q   <= '0;
    end else if (step_acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      ch_q   <= ch_d;
      img_q  <= img_d;
      ocr_q  <= ocr_d;
      bom_q  <= bom_d;
      lin_q  <= lin_d;
      perm_q <= perm_d;
      rs_q   <= rs_d;
      cs_q   <= cs_d;
      grp_q  <= grp_d;
      ib_q   <= ib_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= step_acc || (out_valid_q && !addr_o.ready);
    end
  end

  // Output payload: forward mode reads linear and writes permuted.
  always_ff @(posedge clk_i) begin
    if (step_acc) begin
      out_src_q  <= fwd_q ? cur_lin : cur_perm;
      out_dst_q  <= fwd_q ? cur_perm : cur_lin;
      out_last_q <= is_last;
    end
  end

  assign addr_o.valid          = out_valid_q;
  assign addr_o.source_address = out_src_q;
  assign addr_o.dest_address   = out_dst_q;
  assign addr_o.last           = out_last_q;

endmodule

>>> sim/reorg_address_generator_core_tb.sv
// ----------------------------------------------------------------------------
// Reorg address generator core testbench
// Drives step beats and shape writes into the core and scores every address
// pair against a cycle-free predictor of the space-to-depth walk. The run
// first walks a short table of directed rows, then a series of random shapes.
// Both sides of the pair channel idle at random.
// ----------------------------------------------------------------------------
module reorg_address_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rag_pkg::*;

  localparam int unsigned AddrBits   = DefAddrBits;
  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned NumPhases  = 14;
  localparam int unsigned PhaseBeats = 68;
  localparam int unsigned TailCycles = 8;

  // Register indices that the core does not decode.
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_STEP} row_kind_e;
  typedef enum int unsigned {SHAPE_TINY, SHAPE_DEEP, SHAPE_WIDE, SHAPE_JUNK} shape_kind_e;

  typedef struct packed {
    logic [AddrBits-1:0] src;
    logic [AddrBits-1:0] dst;
    logic                last;
  } addr_pair_t;

  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   index;
    logic [CfgDataW-1:0]  data;
    logic                 restart;
    bit                   known;
    addr_pair_t           pair;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  rag_cfg_if                           cfg_bus ();
  rag_step_if                          step_bus ();
  rag_addr_if #(.ADDR_BITS(AddrBits))  addr_bus ();

  reorg_address_generator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .step_i (step_bus),
    .addr_o (addr_bus)
  );

  // Shape as the core holds it after saturation.
  int unsigned dim_w, dim_h, dim_c, dim_b, dim_s, out_ch;
  bit          scatter;
  // Walk position: the element that the next step beat emits.
  logic [9:0]  pos_col, pos_row;
  logic [11:0] pos_ch, pos_rem;
  logic [5:0]  pos_img;
  logic [12:0] pos_blk;

  addr_pair_t  pending_pairs[$];
  dir_row_t    dir_rows[$];

  int unsigned errors, cycle_count;
  int unsigned pairs_checked, lasts_seen, steps_sent, restarts_sent, shape_writes;
  bit          step_up, cfg_up, calm, hold_request;

  // --------------------------------------------------------------------------
  // Predictor of the walk.
  // --------------------------------------------------------------------------
  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_walk();
    pos_col = '0;
    pos_row = '0;
    pos_ch  = '0;
    pos_img = '0;
    pos_rem = '0;
    pos_blk = '0;
  endfunction

  function automatic void reset_shape();
    dim_w   = 1;
    dim_h   = 1;
    dim_c   = 1;
    dim_b   = 1;
    dim_s   = 1;
    scatter = 1'b1;
    out_ch  = 1;
    clear_walk();
  endfunction

  function automatic void apply_shape_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    int unsigned q;
    case (idx)
      REG_WIDTH:    dim_w = clamp_dim(val[WidthFieldW-1:0], DefMaxWidth);
      REG_HEIGHT:   dim_h = clamp_dim(val[HeightFieldW-1:0], DefMaxHeight);
      REG_CHANNELS: dim_c = clamp_dim(val[ChannelsFieldW-1:0], DefMaxChannels);
      REG_BATCH:    dim_b = clamp_dim(val[BatchFieldW-1:0], DefMaxBatch);
      REG_STRIDE:   dim_s = clamp_dim(val[StrideFieldW-1:0], StrideMax);
      REG_FORWARD:  scatter = val[0];
      default:      return;
    endcase
    q = dim_c / (dim_s * dim_s);
    out_ch = (q == 0) ? 1 : q;
    clear_walk();
  endfunction

  function automatic addr_pair_t next_address_pair(logic restart);
    longint unsigned c, r, ch, im, rem, blk, w, h, cc, s, oc;
    longint unsigned lin, perm, w2, h2;
    int unsigned     nc, nr, nch, nrem, nblk, nimg;
    addr_pair_t      pair;
    if (restart) clear_walk();
    c   = pos_col;
    r   = pos_row;
    ch  = pos_ch;
    im  = pos_img;
    rem = pos_rem;
    blk = pos_blk;
    w   = dim_w;
    h   = dim_h;
    cc  = dim_c;
    s   = dim_s;
    oc  = out_ch;
    lin  = c + w * (r + h * (ch + cc * im));
    w2   = c * s + blk % s;
    h2   = r * s + blk / s;
    perm = w2 + w * s * (h2 + h * s * (rem + oc * im));
    pair.src  = scatter ? lin[AddrBits-1:0] : perm[AddrBits-1:0];
    pair.dst  = scatter ? perm[AddrBits-1:0] : lin[AddrBits-1:0];
    pair.last = (c + 1 == w) && (r + 1 == h) && (ch + 1 == cc) && (im + 1 == dim_b);
    // Advance column first, carrying into row, channel and image.
    nc   = pos_col + 1;
    nr   = pos_row;
    nch  = pos_ch;
    nrem = pos_rem;
    nblk = pos_blk;
    nimg = pos_img;
    if (nc >= dim_w) begin
      nc = 0;
      nr = nr + 1;
      if (nr >= dim_h) begin
        nr   = 0;
        nch  = nch + 1;
        nrem = nrem + 1;
        if (nrem >= out_ch) begin
          nrem = 0;
          nblk = nblk + 1;
        end
        if (nch >= dim_c) begin
          nch  = 0;
          nrem = 0;
          nblk = 0;
          nimg = nimg + 1;
          if (nimg >= dim_b) nimg = 0;
        end
      end
    end
    pos_col = nc[9:0];
    pos_row = nr[9:0];
    pos_ch  = nch[11:0];
    pos_rem = nrem[11:0];
    pos_blk = nblk[12:0];
    pos_img = nimg[5:0];
    return pair;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table rows.
  // --------------------------------------------------------------------------
  function automatic dir_row_t row_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    dir_row_t row;
    row.kind    = ROW_WRITE;
    row.index   = idx;
    row.data    = val;
    row.restart = 1'b0;
    row.known   = 1'b0;
    row.pair    = '0;
    return row;
  endfunction

  function automatic dir_row_t row_step(logic restart);
    dir_row_t row;
    row = row_write(REG_WIDTH, '0);
    row.kind    = ROW_STEP;
    row.restart = restart;
    return row;
  endfunction

  function automatic dir_row_t row_known(logic restart, longint unsigned src,
                                         longint unsigned dst, logic last);
    dir_row_t row;
    row = row_step(restart);
    row.known     = 1'b1;
    row.pair.src  = src[AddrBits-1:0];
    row.pair.dst  = dst[AddrBits-1:0];
    row.pair.last = last;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers. Each signal gets at most one nonblocking write per edge.
  // --------------------------------------------------------------------------
  task automatic drain_pairs();
    if (step_up) step_bus.valid <= 1'b0;
    if (cfg_up) cfg_bus.valid <= 1'b0;
    step_up = 1'b0;
    cfg_up  = 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    if (step_up || pending_pairs.size() != 0) drain_pairs();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    cfg_up = 1'b1;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    apply_shape_write(idx, val);
    shape_writes++;
  endtask

  // Offers one step beat and returns at the edge that takes it.
  task automatic offer_step(logic restart, output addr_pair_t pair);
    if (cfg_up) cfg_bus.valid <= 1'b0;
    cfg_up = 1'b0;
    step_bus.valid   <= 1'b1;
    step_bus.restart <= restart;
    step_up = 1'b1;
    @(posedge clk_i);
    while (!step_bus.ready) @(posedge clk_i);
    pair = next_address_pair(restart);
    steps_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic idle_sender(int unsigned n);
    if (n != 0) begin
      if (step_up) step_bus.valid <= 1'b0;
      step_up = 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic int unsigned sender_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Raw register data for a random shape of the given flavour.
  function automatic logic [CfgDataW-1:0] shape_data(logic [CfgIdxW-1:0] idx,
                                                     shape_kind_e kind);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (kind == SHAPE_JUNK || idx == REG_FORWARD || roll == 0) return CfgDataW'($urandom());
    if (roll == 1) return '0;
    case (idx)
      REG_WIDTH: begin
        if (kind == SHAPE_TINY) return CfgDataW'($urandom_range(1, 4));
        if (kind == SHAPE_DEEP) return CfgDataW'(1);
        return $urandom_range(0, 1) ? CfgDataW'(DefMaxWidth) : CfgDataW'($urandom_range(1, 1024));
      end
      REG_HEIGHT: begin
        if (kind == SHAPE_TINY) return CfgDataW'($urandom_range(1, 4));
        if (kind == SHAPE_DEEP) return CfgDataW'(1);
        return CfgDataW'($urandom_range(1, 2));
      end
      REG_CHANNELS: begin
        if (kind == SHAPE_TINY) return CfgDataW'($urandom_range(1, 16));
        if (kind == SHAPE_DEEP) return CfgDataW'($urandom_range(1, 70));
        return CfgDataW'($urandom_range(1, 4));
      end
      REG_BATCH: begin
        if (kind == SHAPE_TINY) return CfgDataW'($urandom_range(1, 3));
        if (kind == SHAPE_DEEP) begin
          return ($urandom_range(0, 3) == 0) ? CfgDataW'(DefMaxBatch)
                                             : CfgDataW'($urandom_range(1, 20));
        end
        return CfgDataW'($urandom_range(1, 2));
      end
      default: begin
        if (kind == SHAPE_TINY) return CfgDataW'($urandom_range(1, 4));
        return CfgDataW'($urandom_range(1, StrideMax));
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and the cycle limit.
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Run stopped at the cycle limit with %0d pairs outstanding.",
               pending_pairs.size());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready, with one long hold-off when asked for.
  // --------------------------------------------------------------------------
  initial begin : drive_ready
    int unsigned run_left;
    int unsigned hold_left;
    logic        level;
    run_left  = 0;
    hold_left = 0;
    level     = 1'b0;
    addr_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LongHold;
      end
      if (hold_left != 0) begin
        level = 1'b0;
        hold_left--;
      end else if (calm) begin
        level = 1'b1;
      end else begin
        if (run_left == 0) begin
          level = ~level;
          if (level) begin
            run_left = $urandom_range(1, 24);
          end else if ($urandom_range(0, 19) == 0) begin
            run_left = $urandom_range(20, 40);
          end else begin
            run_left = $urandom_range(1, 4);
          end
        end
        run_left--;
      end
      addr_bus.ready <= level;
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard: each pair beat against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : score_pairs
    addr_pair_t want;
    if (rst_ni && addr_bus.valid && addr_bus.ready) begin
      if (pending_pairs.size() == 0) begin
        $error("address pair beat with nothing expected: src %0d dst %0d last %0b",
               addr_bus.source_address, addr_bus.dest_address, addr_bus.last);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        pairs_checked++;
        if (addr_bus.last) lasts_seen++;
        if (addr_bus.source_address !== want.src) begin
          $error("source_address: expected %0d, got %0d", want.src, addr_bus.source_address);
          errors++;
        end
        if (addr_bus.dest_address !== want.dst) begin
          $error("dest_address: expected %0d, got %0d", want.dst, addr_bus.dest_address);
          errors++;
        end
        if (addr_bus.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, addr_bus.last);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin : run_stimulus
    addr_pair_t  pair;
    dir_row_t    row;
    shape_kind_e kind;
    int unsigned first_reg;
    logic        restart;

    rst_ni           = 1'b0;
    step_bus.valid   = 1'b0;
    step_bus.restart = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    errors        = 0;
    cycle_count   = 0;
    pairs_checked = 0;
    lasts_seen    = 0;
    steps_sent    = 0;
    restarts_sent = 0;
    shape_writes  = 0;
    step_up       = 1'b0;
    cfg_up        = 1'b0;
    calm          = 1'b0;
    hold_request  = 1'b0;
    reset_shape();

    // Reset shape is one element, so every step is the last one.
    dir_rows.push_back(row_known(1'b0, 0, 0, 1'b1));
    dir_rows.push_back(row_known(1'b1, 0, 0, 1'b1));
    dir_rows.push_back(row_known(1'b0, 0, 0, 1'b1));
    // Zero width is taken as one; an oversized width saturates.
    dir_rows.push_back(row_write(REG_WIDTH, 13'h0000));
    dir_rows.push_back(row_write(REG_WIDTH, 13'h1FFF));
    dir_rows.push_back(row_known(1'b0, 0, 0, 1'b0));
    dir_rows.push_back(row_known(1'b0, 1, 1, 1'b0));
    dir_rows.push_back(row_known(1'b1, 0, 0, 1'b0));
    // Height with only bits above the field set reads as zero, so one.
    dir_rows.push_back(row_write(REG_HEIGHT, 13'h0800));
    dir_rows.push_back(row_write(REG_CHANNELS, 13'h1FFF));
    dir_rows.push_back(row_write(REG_BATCH, 13'h1FFF));
    dir_rows.push_back(row_write(REG_STRIDE, 13'h000F));
    dir_rows.push_back(row_known(1'b0, 0, 0, 1'b0));
    dir_rows.push_back(row_known(1'b0, 1, 8, 1'b0));
    dir_rows.push_back(row_step(1'b0));
    // Gather mode swaps the two addresses.
    dir_rows.push_back(row_write(REG_FORWARD, 13'h1FFE));
    dir_rows.push_back(row_known(1'b0, 0, 0, 1'b0));
    dir_rows.push_back(row_known(1'b0, 8, 1, 1'b0));
    // Writes to undecoded indices leave shape and walk alone.
    dir_rows.push_back(row_write(REG_SPARE_LO, 13'h1555));
    dir_rows.push_back(row_step(1'b0));
    dir_rows.push_back(row_write(REG_SPARE_HI, 13'h0AAA));
    dir_rows.push_back(row_step(1'b0));
    dir_rows.push_back(row_write(REG_STRIDE, 13'h0000));
    dir_rows.push_back(row_write(REG_FORWARD, 13'h0001));
    // Too few channels for the stride: one output channel.
    dir_rows.push_back(row_write(REG_WIDTH, 13'h0001));
    dir_rows.push_back(row_write(REG_CHANNELS, 13'h0003));
    dir_rows.push_back(row_write(REG_STRIDE, 13'h0002));
    dir_rows.push_back(row_write(REG_BATCH, 13'h0001));
    repeat (3) dir_rows.push_back(row_step(1'b0));
    // Channels not a multiple of stride squared: block offset runs past it.
    dir_rows.push_back(row_write(REG_CHANNELS, 13'h0005));
    repeat (5) dir_rows.push_back(row_step(1'b0));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_WRITE) begin
        write_reg(row.index, row.data);
      end else begin
        offer_step(row.restart, pair);
        pending_pairs.push_back(row.known ? row.pair : pair);
        idle_sender(sender_gap());
      end
    end
    drain_pairs();

    // Random shapes, each written while the core is idle.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      kind = shape_kind_e'(p % 4);
      calm = (p == 3) || (p == 9);
      if (p % 3 == 2) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  CfgDataW'($urandom()));
      end
      first_reg = $urandom_range(0, 5);
      for (int unsigned k = 0; k < 6; k++) begin
        write_reg(CfgIdxW'((first_reg + k) % 6), shape_data(CfgIdxW'((first_reg + k) % 6), kind));
      end
      if (p == 5 || p == 12) hold_request = 1'b1;
      for (int unsigned n = 0; n < PhaseBeats; n++) begin
        if (p == 10) restart = $urandom_range(0, 1);
        else restart = ($urandom_range(0, 24) == 0);
        // Mid-phase, let every outstanding pair leave before going on.
        if (p == 7 && n == PhaseBeats / 2) drain_pairs();
        offer_step(restart, pair);
        pending_pairs.push_back(pair);
        if (p != 5 && p != 12) idle_sender(sender_gap());
      end
      drain_pairs();
    end
    calm = 1'b0;

    drain_pairs();
    repeat (TailCycles) @(posedge clk_i);
    if (pending_pairs.size() != 0) begin
      $error("%0d address pairs never arrived", pending_pairs.size());
      errors++;
    end

    $display("Sent %0d step beats (%0d restarts) and %0d register writes over %0d shapes.",
             steps_sent, restarts_sent, shape_writes, NumPhases + 1);
    $display("Checked %0d address pairs, %0d of them flagged last; %0d mismatches.",
             pairs_checked, lasts_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
